@@ rtl/ustc_pkg.sv @@
// constants and helpers shared by the unix seconds to calendar pipeline
// no dependencies
package ustc_pkg;

    // seconds to day count: (secs >> 7) / 675 by reciprocal, shift 36
    localparam logic [26:0] DAY_RECIP    = 27'd101806633;
    localparam logic [16:0] SEC_PER_DAY  = 17'd86400;

    // time of day
    localparam logic [12:0] HOUR_RECIP   = 13'd4661;    // (sod >> 4) / 225, shift 20
    localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
    localparam logic [10:0] MIN_RECIP    = 11'd1093;    // (rem >> 2) / 15, shift 14
    localparam logic [11:0] SEC_PER_MIN  = 12'd60;

    // weekday: (days + 3) mod 7, reciprocal shift 19
    localparam logic [15:0] WDAY_OFS     = 16'd3;
    localparam logic [16:0] WDAY_RECIP   = 17'd74899;
    localparam logic [15:0] DAYS_PER_WK  = 16'd7;

    // julian day conversion, a = days + 2440588 + 32044
    localparam logic [21:0] JDN_A_OFS    = 22'd2472632;
    localparam logic [23:0] CENT_EDGE_68 = 24'd9934596;
    localparam logic [23:0] CENT_EDGE_69 = 24'd10080693;
    localparam logic [21:0] CENT_BASE_67 = 22'd2447124;
    localparam logic [21:0] CENT_BASE_68 = 22'd2483649;
    localparam logic [21:0] CENT_BASE_69 = 22'd2520173;
    localparam logic [1:0]  CENT_IDX_67  = 2'd0;
    localparam logic [1:0]  CENT_IDX_68  = 2'd1;
    localparam logic [1:0]  CENT_IDX_69  = 2'd2;
    localparam logic [17:0] Y4_RECIP     = 18'd183735;  // / 1461, shift 28
    localparam logic [17:0] DAYS_PER_4Y  = 18'd1461;
    localparam logic [12:0] MON_RECIP    = 13'd6854;    // / 153, shift 20
    localparam logic [3:0]  MON_WRAP     = 4'd10;
    localparam logic [11:0] YEAR_BASE    = 12'd1900;
    localparam logic [11:0] YEARS_PER_C  = 12'd100;

    // first day of each month counted from march
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

@@ rtl/unix_seconds_to_calendar.sv @@
// top level: unix seconds to calendar date and time of day
// depends on ustc_pkg, ustc_tod and ustc_date
//
// usage:
//   a request is taken at a rising edge with start high and busy low.
//   busy never rises, so a request may be issued in every cycle.
//   each request gives one result, shown for one cycle with o_valid high,
//   once it has passed the input, day product and day count registers and then both branches.
//   throughput is one request per cycle; results leave in request order.
//   the receiver cannot hold results off and needs no handshake back.
//   latency is set by the chain of constant reciprocal multiplies:
//   day count, then hour and minute in one branch and
//   four year group and month in the other.
//   synchronous reset clears all valid bits; requests in flight are dropped.
//   the block keeps no state between requests.
module unix_seconds_to_calendar import ustc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_unix_seconds,
    output logic        o_valid,
    output logic [5:0]  o_second,
    output logic [5:0]  o_minute,
    output logic [4:0]  o_hour,
    output logic [2:0]  o_weekday,
    output logic [4:0]  o_day_of_month,
    output logic [3:0]  o_month,
    output logic [11:0] o_year
);

    logic [7:0]  r_vld;
    logic [7:0]  n_vld;
    logic [31:0] r_secs0;
    logic [51:0] r_dprod1;
    logic [31:0] r_secs1;
    logic [15:0] r_days2;
    logic [31:0] r_secs2;

    assign busy  = 1'b0;
    assign n_vld = {r_vld[6:0], start & ~busy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_secs0  <= i_unix_seconds;
        r_dprod1 <= 52'(r_secs0[31:7]) * 52'(DAY_RECIP);
        r_secs1  <= r_secs0;
        r_days2  <= r_dprod1[51:36];
        r_secs2  <= r_secs1;
    end

    ustc_tod u_tod (
        .i_clk    (i_clk),
        .i_secs   (r_secs2),
        .i_days   (r_days2),
        .o_second (o_second),
        .o_minute (o_minute),
        .o_hour   (o_hour)
    );

    ustc_date u_date (
        .i_clk          (i_clk),
        .i_days         (r_days2),
        .o_weekday      (o_weekday),
        .o_day_of_month (o_day_of_month),
        .o_month        (o_month),
        .o_year         (o_year)
    );

    assign o_valid = r_vld[7];

endmodule

@@ rtl/ustc_tod.sv @@
// time of day pipeline: second, minute and hour from seconds and day count
// depends on ustc_pkg
module ustc_tod import ustc_pkg::*; (
    input  logic        i_clk,
    input  logic [31:0] i_secs,
    input  logic [15:0] i_days,
    output logic [5:0]  o_second,
    output logic [5:0]  o_minute,
    output logic [4:0]  o_hour
);

    logic [32:0] n_dsec;
    logic [16:0] r_sod3;
    logic [25:0] r_hprod;
    logic [16:0] r_sod4;
    logic [4:0]  n_hour;
    logic [16:0] n_rem;
    logic [4:0]  r_hour5;
    logic [11:0] r_rem5;
    logic [20:0] r_mprod;
    logic [11:0] r_rem6;
    logic [4:0]  r_hour6;
    logic [5:0]  n_minute;
    logic [11:0] n_sec;
    logic [5:0]  r_second;
    logic [5:0]  r_minute;
    logic [4:0]  r_hour;

    assign n_dsec   = 33'(i_days) * 33'(SEC_PER_DAY);
    assign n_hour   = r_hprod[24:20];
    assign n_rem    = r_sod4 - 17'(n_hour) * 17'(SEC_PER_HOUR);
    assign n_minute = r_mprod[19:14];
    assign n_sec    = r_rem6 - 12'(n_minute) * SEC_PER_MIN;

    always_ff @(posedge i_clk) begin
        r_sod3   <= i_secs[16:0] - n_dsec[16:0];
        r_hprod  <= 26'(r_sod3[16:4]) * 26'(HOUR_RECIP);
        r_sod4   <= r_sod3;
        r_hour5  <= n_hour;
        r_rem5   <= n_rem[11:0];
        r_mprod  <= 21'(r_rem5[11:2]) * 21'(MIN_RECIP);
        r_rem6   <= r_rem5;
        r_hour6  <= r_hour5;
        r_second <= n_sec[5:0];
        r_minute <= n_minute;
        r_hour   <= r_hour6;
    end

    assign o_second = r_second;
    assign o_minute = r_minute;
    assign o_hour   = r_hour;

endmodule

@@ rtl/ustc_date.sv @@
// date pipeline: weekday, day of month, month and year from the day count
// through the julian day number; depends on ustc_pkg
module ustc_date import ustc_pkg::*; (
    input  logic        i_clk,
    input  logic [15:0] i_days,
    output logic [2:0]  o_weekday,
    output logic [4:0]  o_day_of_month,
    output logic [3:0]  o_month,
    output logic [11:0] o_year
);

    logic [15:0] n_wx;
    logic [21:0] n_a;
    logic [23:0] n_x;
    logic [1:0]  n_cidx;
    logic [21:0] n_cbase;
    logic [21:0] n_c;
    logic [15:0] r_wx3;
    logic [32:0] r_wprod3;
    logic [15:0] r_c3;
    logic [1:0]  r_cidx3;
    logic [15:0] n_wr;
    logic [2:0]  r_wday4;
    logic [35:0] r_yprod4;
    logic [15:0] r_c4;
    logic [1:0]  r_cidx4;
    logic [7:0]  n_yr4;
    logic [17:0] n_y4d;
    logic [15:0] n_e;
    logic [2:0]  r_wday5;
    logic [8:0]  r_e5;
    logic [7:0]  r_yr45;
    logic [1:0]  r_cidx5;
    logic [10:0] n_mx;
    logic [2:0]  r_wday6;
    logic [23:0] r_mprod6;
    logic [8:0]  r_e6;
    logic [7:0]  r_yr46;
    logic [1:0]  r_cidx6;
    logic [3:0]  n_m;
    logic        n_wrap;
    logic [8:0]  n_mday;
    logic [3:0]  n_mon;
    logic [11:0] n_year;
    logic [2:0]  r_weekday;
    logic [4:0]  r_day_of_month;
    logic [3:0]  r_month;
    logic [11:0] r_year;

    // century of the 400 year cycle, only three can occur
    always_comb begin
        n_wx = i_days + WDAY_OFS;
        n_a  = 22'(i_days) + JDN_A_OFS;
        n_x  = {n_a, 2'b11};
        if (n_x >= CENT_EDGE_69) begin
            n_cidx  = CENT_IDX_69;
            n_cbase = CENT_BASE_69;
        end else if (n_x >= CENT_EDGE_68) begin
            n_cidx  = CENT_IDX_68;
            n_cbase = CENT_BASE_68;
        end else begin
            n_cidx  = CENT_IDX_67;
            n_cbase = CENT_BASE_67;
        end
        n_c = n_a - n_cbase;
    end

    assign n_wr  = r_wx3 - DAYS_PER_WK * r_wprod3[31:19]
                   ;
    assign n_yr4 = r_yprod4[35:28];
    assign n_y4d = 18'(n_yr4) * DAYS_PER_4Y;
    assign n_e   = r_c4 - n_y4d[17:2];
    assign n_mx  = {r_e5, 2'b00} + 11'(r_e5) + 11'd2;

    always_comb begin
        n_m    = r_mprod6[23:20];
        n_wrap = (n_m >= MON_WRAP);
        n_mday = r_e6 - month_start(n_m) + 9'd1;
        n_mon  = n_wrap ? (n_m - 4'd9) : (n_m + 4'd3);
        n_year = YEAR_BASE + 12'(r_cidx6) * YEARS_PER_C + 12'(r_yr46) + 12'(n_wrap);
    end

    always_ff @(posedge i_clk) begin
        r_wx3          <= n_wx;
        r_wprod3       <= 33'(n_wx) * 33'(WDAY_RECIP);
        r_c3           <= n_c[15:0];
        r_cidx3        <= n_cidx;
        r_wday4        <= n_wr[2:0] + 3'd1;
        r_yprod4       <= 36'({r_c3, 2'b11}) * 36'(Y4_RECIP);
        r_c4           <= r_c3;
        r_cidx4        <= r_cidx3;
        r_wday5        <= r_wday4;
        r_e5           <= n_e[8:0];
        r_yr45         <= n_yr4;
        r_cidx5        <= r_cidx4;
        r_wday6        <= r_wday5;
        r_mprod6       <= 24'(n_mx) * 24'(MON_RECIP);
        r_e6           <= r_e5;
        r_yr46         <= r_yr45;
        r_cidx6        <= r_cidx5;
        r_weekday      <= r_wday6;
        r_day_of_month <= n_mday[4:0];
        r_month        <= n_mon;
        r_year         <= n_year;
    end

    assign o_weekday      = r_weekday;
    assign o_day_of_month = r_day_of_month;
    assign o_month        = r_month;
    assign o_year         = r_year;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// testbench for unix_seconds_to_calendar: directed table of timestamps, then random requests
// every result is checked against a behavioral calendar model or a hand-written expected value; depends on the rtl

module testbench;

    localparam int  MAX_MISMATCH_REPORTS = 10;
    localparam int  STALL_LIMIT          = 2000;
    localparam int  PIPE_LATENCY         = 7;
    localparam int  RANDOM_REQUESTS      = 1830;
    localparam int  BLOCK_SIZE           = 100;
    localparam int  MAX_GAP              = 11;

    localparam longint unsigned HALF_DAY    = 43200;
    localparam longint unsigned EPOCH_JDN   = 2440587;
    localparam longint unsigned JDN_SHIFT   = 32044;
    localparam longint unsigned DAYS_400Y   = 146097;
    localparam longint unsigned DAYS_4Y     = 1461;
    localparam longint unsigned MONTH_SPAN  = 153;
    localparam longint unsigned YEAR_SHIFT  = 4800;
    localparam longint unsigned SECS_IN_DAY = 86400;
    localparam longint unsigned LAST_DAY    = 49709;

    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [2:0]  weekday;
        logic [4:0]  day_of_month;
        logic [3:0]  month;
        logic [11:0] year;
    } t_calendar;

    typedef struct {
        logic [31:0] secs;
        bit          typed;
        t_calendar   want;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_unix_seconds;
    logic        o_valid;
    logic [5:0]  o_second;
    logic [5:0]  o_minute;
    logic [4:0]  o_hour;
    logic [2:0]  o_weekday;
    logic [4:0]  o_day_of_month;
    logic [3:0]  o_month;
    logic [11:0] o_year;

    t_calendar   pending_dates[$];
    t_stim_row   directed_rows[$];
    int          mismatch_count;
    int          requests_sent;
    int          dates_checked;
    int          idle_cycles;

    unix_seconds_to_calendar dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_unix_seconds (i_unix_seconds),
        .o_valid        (o_valid),
        .o_second       (o_second),
        .o_minute       (o_minute),
        .o_hour         (o_hour),
        .o_weekday      (o_weekday),
        .o_day_of_month (o_day_of_month),
        .o_month        (o_month),
        .o_year         (o_year)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_calendar calendar_of_seconds(input logic [31:0] secs);
        longint unsigned s, jdn, mins, hrs, a, cent, c, yr4, e, m, wrap;
        t_calendar r;
        s    = secs;
        jdn  = ((s + HALF_DAY) / HALF_DAY + 2 * EPOCH_JDN + 1) >> 1;
        mins = s / 60;
        hrs  = mins / 60;
        a    = jdn + JDN_SHIFT;
        cent = (4 * a + 3) / DAYS_400Y;
        c    = a - (DAYS_400Y * cent) / 4;
        yr4  = (4 * c + 3) / DAYS_4Y;
        e    = c - (DAYS_4Y * yr4) / 4;
        m    = (5 * e + 2) / MONTH_SPAN;
        wrap = m / 10;
        r.second       = 6'(s - mins * 60);
        r.minute       = 6'(mins - hrs * 60);
        r.hour         = 5'(hrs % 24);
        r.weekday      = 3'(jdn % 7 + 1);
        r.day_of_month = 5'(e - (MONTH_SPAN * m + 2) / 5 + 1);
        r.month        = 4'(m + 3 - 12 * wrap);
        r.year         = 12'(100 * cent + yr4 + wrap - YEAR_SHIFT);
        return r;
    endfunction

    // random timestamp: uniform, near the top of the range, or near a day or half-day edge
    function automatic logic [31:0] pick_seconds();
        longint unsigned t;
        int unsigned     kind;
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
            t = $urandom;
        end else if (kind < 6) begin
            t = 64'hFFFF_FFFF - $urandom_range(0, 200000);
        end else begin
            t = longint'($urandom_range(0, LAST_DAY)) * SECS_IN_DAY;
            case ($urandom_range(0, 4))
                0:       t = t;
                1:       t = t + 1;
                2:       t = t + HALF_DAY - 1;
                3:       t = t + HALF_DAY;
                default: t = t + SECS_IN_DAY - 1;
            endcase
        end
        return t[31:0];
    endfunction

    task automatic send_request(input logic [31:0] secs, input t_calendar want, input int gap);
        start          <= 1'b1;
        i_unix_seconds <= secs;
        do @(posedge i_clk); while (busy);
        pending_dates.push_back(want);
        requests_sent++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_dates.size() != 0) @(posedge i_clk);
    endtask

    // result checker and watchdog
    always @(posedge i_clk) begin
        t_calendar got, want;
        string     bad;
        if (i_rst_n) begin
            if ((start && !busy) || o_valid) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no request or result for %0d cycles", STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            if (o_valid) begin
                got = '{o_second, o_minute, o_hour, o_weekday, o_day_of_month, o_month, o_year};
                if (pending_dates.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_MISMATCH_REPORTS)
                        $display("unexpected result %p at %0t", got, $realtime);
                end else begin
                    want = pending_dates.pop_front();
                    dates_checked++;
                    bad = "";
                    if (got.second !== want.second) bad = {bad, " second"};
                    if (got.minute !== want.minute) bad = {bad, " minute"};
                    if (got.hour !== want.hour) bad = {bad, " hour"};
                    if (got.weekday !== want.weekday) bad = {bad, " weekday"};
                    if (got.day_of_month !== want.day_of_month) bad = {bad, " day_of_month"};
                    if (got.month !== want.month) bad = {bad, " month"};
                    if (got.year !== want.year) bad = {bad, " year"};
                    if (bad != "") begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_MISMATCH_REPORTS)
                            $display("mismatch in%s: expected %p, got %p", bad, want, got);
                    end
                end
            end
        end
    end

    initial begin
        t_calendar want;
        bit        burst;
        int        gap;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_unix_seconds = '0;
        mismatch_count = 0;
        requests_sent  = 0;
        dates_checked  = 0;
        idle_cycles    = 0;

        // epoch, day and half-day edges, leap days, 2038, 2100 and top of range
        directed_rows.push_back('{32'd0, 1'b1, '{6'd0, 6'd0, 5'd0, 3'd4, 5'd1, 4'd1, 12'd1970}});
        directed_rows.push_back('{32'd43199, 1'b0, '0});
        directed_rows.push_back('{32'd43200, 1'b0, '0});
        directed_rows.push_back('{32'd86399, 1'b0, '0});
        directed_rows.push_back('{32'd86400, 1'b0, '0});
        directed_rows.push_back('{32'd68169600, 1'b0, '0});
        directed_rows.push_back('{32'd946684799, 1'b0, '0});
        directed_rows.push_back('{32'd946684800, 1'b1,
                                  '{6'd0, 6'd0, 5'd0, 3'd6, 5'd1, 4'd1, 12'd2000}});
        directed_rows.push_back('{32'd951782400, 1'b1,
                                  '{6'd0, 6'd0, 5'd0, 3'd2, 5'd29, 4'd2, 12'd2000}});
        directed_rows.push_back('{32'd951868800, 1'b0, '0});
        directed_rows.push_back('{32'd2147483647, 1'b0, '0});
        directed_rows.push_back('{32'd2147483648, 1'b0, '0});
        directed_rows.push_back('{32'd4107455999, 1'b0, '0});
        directed_rows.push_back('{32'd4107456000, 1'b0, '0});
        directed_rows.push_back('{32'd4107542400, 1'b0, '0});
        directed_rows.push_back('{32'hAAAA_AAAA, 1'b0, '0});
        directed_rows.push_back('{32'h5555_5555, 1'b0, '0});
        directed_rows.push_back('{32'hFFFF_0000, 1'b0, '0});
        directed_rows.push_back('{32'd4294923999, 1'b0, '0});
        directed_rows.push_back('{32'd4294943999, 1'b0, '0});
        directed_rows.push_back('{32'd4294944000, 1'b0, '0});
        directed_rows.push_back('{32'hFFFF_FFFE, 1'b0, '0});
        directed_rows.push_back('{32'hFFFF_FFFF, 1'b1,
                                  '{6'd15, 6'd28, 5'd6, 3'd7, 5'd7, 4'd2, 12'd2106}});

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            want = directed_rows[k].typed ? directed_rows[k].want
                                          : calendar_of_seconds(directed_rows[k].secs);
            send_request(directed_rows[k].secs, want, $urandom_range(0, MAX_GAP));
        end
        drain_results();

        // each block of requests is either a back-to-back burst or has random gaps, chosen at random
        burst = 1'b0;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            logic [31:0] secs;
            if (n % BLOCK_SIZE == 0) burst = ($urandom_range(0, 2) == 0);
            if (n == RANDOM_REQUESTS / 2) drain_results();
            secs = pick_seconds();
            gap  = burst ? 0 : $urandom_range(0, MAX_GAP);
            send_request(secs, calendar_of_seconds(secs), gap);
        end

        drain_results();
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);

        $display("sent %0d timestamps (%0d directed), checked %0d calendar results",
                 requests_sent, directed_rows.size(), dates_checked);
        $display("covered epoch, leap days, 2038 and 2100 edges, top of range, random gaps");
        if (mismatch_count == 0 && pending_dates.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_count, pending_dates.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
